// File: hdl/mali_pkg.sv
// Shared constants, types and codes of the multi-axis linear interpolator.
package mali_pkg;

  localparam int AXIS_SLOTS      = 6;
  localparam int DATA_W          = 32;
  localparam int STEP_W          = 7;
  localparam int AXES_W          = 3;
  localparam int DIV_W           = DATA_W + 1;
  localparam int REM_W           = STEP_W + 1;
  localparam int DIV_CNT_W       = $clog2(DIV_W);
  localparam int LANES           = AXIS_SLOTS + 1;
  localparam int TIME_LANE       = AXIS_SLOTS;
  localparam int CFG_INDEX_W     = 2;
  localparam int AXES_LIMIT      = 7;
  localparam int NUM_AXES_RESET  = 6;
  localparam int DEF_MAX_AXES    = 6;
  localparam int DEF_MAX_STEPS   = 64;

  typedef logic signed [DATA_W-1:0] pos_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NUM_AXES   = 2'd0,
    CFG_START_TIME = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_FIX,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit_start;
    logic div_step;
    logic div_fix;
    logic emit_point;
    logic last_point;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              in_start;
    logic              out_free;
    logic [STEP_W-1:0] steps;
  } ctrl_status_t;

endpackage

// File: hdl/mali_ifs.sv
// Handshake channels of the interpolator: input items, output points, register writes.
interface mali_item_if;
  logic                              valid;
  logic                              ready;
  logic                              is_start;
  logic signed [mali_pkg::DATA_W-1:0] target_0;
  logic signed [mali_pkg::DATA_W-1:0] target_1;
  logic signed [mali_pkg::DATA_W-1:0] target_2;
  logic signed [mali_pkg::DATA_W-1:0] target_3;
  logic signed [mali_pkg::DATA_W-1:0] target_4;
  logic signed [mali_pkg::DATA_W-1:0] target_5;
  logic [mali_pkg::STEP_W-1:0]       num_steps;
  logic [mali_pkg::DATA_W-1:0]       travel_period;

  modport source (output valid, is_start, target_0, target_1, target_2, target_3,
                  target_4, target_5, num_steps, travel_period, input ready);
  modport sink   (input valid, is_start, target_0, target_1, target_2, target_3,
                  target_4, target_5, num_steps, travel_period, output ready);
endinterface

interface mali_point_if;
  logic                              valid;
  logic                              ready;
  logic [mali_pkg::DATA_W-1:0]       time_stamp;
  logic signed [mali_pkg::DATA_W-1:0] pos_0;
  logic signed [mali_pkg::DATA_W-1:0] pos_1;
  logic signed [mali_pkg::DATA_W-1:0] pos_2;
  logic signed [mali_pkg::DATA_W-1:0] pos_3;
  logic signed [mali_pkg::DATA_W-1:0] pos_4;
  logic signed [mali_pkg::DATA_W-1:0] pos_5;
  logic                              last_of_run;

  modport source (output valid, time_stamp, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
                  last_of_run, input ready);
  modport sink   (input valid, time_stamp, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
                  last_of_run, output ready);
endinterface

interface mali_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mali_pkg::CFG_INDEX_W-1:0] index;
  logic [mali_pkg::DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/mali_ctrl.sv
// Interpolator controller: sequences accept, division, and point emission.
module mali_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  mali_pkg::ctrl_status_t status,
  output mali_pkg::ctrl_cmd_t    cmd
);

  mali_pkg::state_t                state;
  mali_pkg::state_t                state_next;
  logic [mali_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic [mali_pkg::STEP_W-1:0]     pt_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mali_pkg::ST_IDLE;
      div_cnt <= '0;
      pt_cnt  <= '0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        div_cnt <= mali_pkg::DIV_CNT_W'(mali_pkg::DIV_W - 1);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (cmd.div_fix) begin
        pt_cnt <= mali_pkg::STEP_W'(1);
      end else if (cmd.emit_point) begin
        pt_cnt <= pt_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mali_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = status.in_start ? mali_pkg::ST_START : mali_pkg::ST_DIVIDE;
        end
      end
      mali_pkg::ST_START: begin
        if (status.out_free) begin
          state_next = mali_pkg::ST_IDLE;
        end
      end
      mali_pkg::ST_DIVIDE: begin
        if (div_cnt == '0) begin
          state_next = mali_pkg::ST_FIX;
        end
      end
      mali_pkg::ST_FIX: begin
        state_next = mali_pkg::ST_EMIT;
      end
      mali_pkg::ST_EMIT: begin
        if (status.out_free && (pt_cnt == status.steps)) begin
          state_next = mali_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mali_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      mali_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.accept = item_valid;
      end
      mali_pkg::ST_START: begin
        cmd.emit_start = status.out_free;
      end
      mali_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      mali_pkg::ST_FIX: begin
        cmd.div_fix = 1'b1;
      end
      mali_pkg::ST_EMIT: begin
        cmd.emit_point = status.out_free;
        cmd.last_point = (pt_cnt == status.steps);
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/mali_datapath.sv
// Interpolator datapath: registers, per-lane restoring dividers, accumulators, output word.
module mali_datapath #(
  parameter int MAX_AXES  = mali_pkg::DEF_MAX_AXES,
  parameter int MAX_STEPS = mali_pkg::DEF_MAX_STEPS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mali_pkg::ctrl_cmd_t                  cmd,
  output mali_pkg::ctrl_status_t               status,
  input  logic                                 in_is_start,
  input  mali_pkg::pos_t                       in_target [mali_pkg::AXIS_SLOTS],
  input  logic [mali_pkg::STEP_W-1:0]          in_num_steps,
  input  logic [mali_pkg::DATA_W-1:0]          in_travel_period,
  input  logic                                 cfg_valid,
  input  logic [mali_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mali_pkg::DATA_W-1:0]          cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mali_pkg::DATA_W-1:0]          out_time,
  output mali_pkg::pos_t                       out_pos [mali_pkg::AXIS_SLOTS],
  output logic                                 out_last
);

  localparam int N = mali_pkg::AXIS_SLOTS;

  logic [mali_pkg::AXES_W-1:0]  num_axes;
  logic [mali_pkg::DATA_W-1:0]  start_time;
  logic [N-1:0]                 axis_on;
  logic [mali_pkg::STEP_W-1:0]  steps_in;
  logic [mali_pkg::STEP_W-1:0]  steps;

  mali_pkg::pos_t               cur_pos [N];
  logic [mali_pkg::DATA_W-1:0]  cur_time;
  mali_pkg::pos_t               tgt [N];
  logic [N-1:0]                 neg;
  logic [mali_pkg::DIV_W-1:0]   quo [mali_pkg::LANES];
  logic [mali_pkg::REM_W-1:0]   rem [mali_pkg::LANES];
  mali_pkg::pos_t               step [N];
  logic [mali_pkg::DATA_W-1:0]  dt;
  mali_pkg::pos_t               wpos [N];
  logic [mali_pkg::DATA_W-1:0]  t;

  logic [mali_pkg::DIV_W-1:0]   diff [N];
  logic [mali_pkg::REM_W-1:0]   part [mali_pkg::LANES];
  logic [mali_pkg::LANES-1:0]   fits;
  mali_pkg::pos_t               wpos_next [N];
  logic [mali_pkg::DATA_W-1:0]  t_next;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_axes   <= mali_pkg::AXES_W'(mali_pkg::NUM_AXES_RESET);
      start_time <= '0;
    end else if (cfg_valid) begin
      case (mali_pkg::cfg_reg_t'(cfg_index))
        mali_pkg::CFG_NUM_AXES: begin
          if ((cfg_data[mali_pkg::AXES_W-1:0] != '0) &&
              (cfg_data[mali_pkg::AXES_W-1:0] != mali_pkg::AXES_W'(mali_pkg::AXES_LIMIT))) begin
            num_axes <= cfg_data[mali_pkg::AXES_W-1:0];
          end
        end
        mali_pkg::CFG_START_TIME: begin
          start_time <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      axis_on[i] = (mali_pkg::AXES_W'(i) < num_axes) && (i < MAX_AXES);
    end
  end

  always_comb begin
    if (in_num_steps == '0) begin
      steps_in = mali_pkg::STEP_W'(1);
    end else if (in_num_steps > mali_pkg::STEP_W'(MAX_STEPS)) begin
      steps_in = mali_pkg::STEP_W'(MAX_STEPS);
    end else begin
      steps_in = in_num_steps;
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      diff[i]      = {in_target[i][mali_pkg::DATA_W-1], in_target[i]} -
                     {cur_pos[i][mali_pkg::DATA_W-1], cur_pos[i]};
      wpos_next[i] = wpos[i] + step[i];
    end
    for (int l = 0; l < mali_pkg::LANES; l++) begin
      part[l] = {rem[l][mali_pkg::REM_W-2:0], quo[l][mali_pkg::DIV_W-1]};
      fits[l] = (part[l] >= mali_pkg::REM_W'(steps));
    end
    t_next = t + dt;
  end

  assign status.in_start = in_is_start;
  assign status.out_free = !out_valid || out_ready;
  assign status.steps    = steps;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        cur_pos[i] <= '0;
      end
      cur_time <= '0;
    end else if (cmd.emit_start) begin
      for (int i = 0; i < N; i++) begin
        if (axis_on[i]) begin
          cur_pos[i] <= tgt[i];
        end
      end
      cur_time <= start_time;
    end else if (cmd.emit_point && cmd.last_point) begin
      for (int i = 0; i < N; i++) begin
        if (axis_on[i]) begin
          cur_pos[i] <= tgt[i];
        end
      end
      cur_time <= t_next;
    end
  end

  // divider lanes and accumulators
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < N; i++) begin
        tgt[i] <= in_target[i];
        neg[i] <= diff[i][mali_pkg::DIV_W-1];
        quo[i] <= diff[i][mali_pkg::DIV_W-1] ? -diff[i] : diff[i];
      end
      quo[mali_pkg::TIME_LANE] <= {1'b0, in_travel_period};
      for (int l = 0; l < mali_pkg::LANES; l++) begin
        rem[l] <= '0;
      end
      steps <= steps_in;
    end else if (cmd.div_step) begin
      for (int l = 0; l < mali_pkg::LANES; l++) begin
        rem[l] <= fits[l] ? part[l] - mali_pkg::REM_W'(steps) : part[l];
        quo[l] <= {quo[l][mali_pkg::DIV_W-2:0], fits[l]};
      end
    end
    if (cmd.div_fix) begin
      for (int i = 0; i < N; i++) begin
        step[i] <= neg[i] ? -quo[i][mali_pkg::DATA_W-1:0] : quo[i][mali_pkg::DATA_W-1:0];
        wpos[i] <= cur_pos[i];
      end
      dt <= quo[mali_pkg::TIME_LANE][mali_pkg::DATA_W-1:0];
      t  <= cur_time;
    end else if (cmd.emit_point) begin
      for (int i = 0; i < N; i++) begin
        wpos[i] <= wpos_next[i];
      end
      t <= t_next;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_start || cmd.emit_point) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      out_time <= start_time;
      out_last <= 1'b1;
      for (int i = 0; i < N; i++) begin
        out_pos[i] <= axis_on[i] ? tgt[i] : '0;
      end
    end else if (cmd.emit_point) begin
      out_time <= t_next;
      out_last <= cmd.last_point;
      for (int i = 0; i < N; i++) begin
        out_pos[i] <= axis_on[i] ? wpos_next[i] : '0;
      end
    end
  end

endmodule

// File: hdl/multi_axis_linear_interpolator.sv
// Top level of the multi-axis linear interpolator.
// A start word's single point is loaded into the output register in ST_START,
// once the output register is free. A via word with n steps (1..MAX_STEPS) runs a
// bit-serial restoring divider, one lane per axis plus one for the time
// increment, fixes the signs in ST_FIX, then emits one point per cycle while the
// output register is free; the next word is taken the cycle after the last
// point. The output register lets the last point wait while the next word is
// accepted. Register writes are taken in any cycle.
module multi_axis_linear_interpolator #(
  parameter int MAX_AXES  = mali_pkg::DEF_MAX_AXES,
  parameter int MAX_STEPS = mali_pkg::DEF_MAX_STEPS
) (
  input  logic          clk,
  input  logic          rst,
  mali_item_if.sink     item,
  mali_point_if.source  point,
  mali_cfg_if.sink      cfg
);

  mali_pkg::ctrl_cmd_t    cmd;
  mali_pkg::ctrl_status_t status;
  mali_pkg::pos_t         target [mali_pkg::AXIS_SLOTS];
  mali_pkg::pos_t         pos [mali_pkg::AXIS_SLOTS];

  assign target[0] = item.target_0;
  assign target[1] = item.target_1;
  assign target[2] = item.target_2;
  assign target[3] = item.target_3;
  assign target[4] = item.target_4;
  assign target[5] = item.target_5;

  assign point.pos_0 = pos[0];
  assign point.pos_1 = pos[1];
  assign point.pos_2 = pos[2];
  assign point.pos_3 = pos[3];
  assign point.pos_4 = pos[4];
  assign point.pos_5 = pos[5];

  assign cfg.ready = 1'b1;

  mali_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  mali_datapath #(
    .MAX_AXES  (MAX_AXES),
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_is_start      (item.is_start),
    .in_target        (target),
    .in_num_steps     (item.num_steps),
    .in_travel_period (item.travel_period),
    .cfg_valid        (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .out_valid        (point.valid),
    .out_ready        (point.ready),
    .out_time         (point.time_stamp),
    .out_pos          (pos),
    .out_last         (point.last_of_run)
  );

endmodule

// File: hdl/mali_checker.sv
// Port-level checks of the interpolator and their binding to the top level.
module mali_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic point_valid,
  input logic point_ready,
  input logic point_last
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !point_valid)
    else $error("output word valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("input ready right after an accepted word");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_last) |-> !item_ready)
    else $error("input ready while a run is still emitting");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_ready) |=> point_valid)
    else $error("stalled output word dropped");

endmodule

bind multi_axis_linear_interpolator mali_checker u_mali_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .point_valid (point.valid),
  .point_ready (point.ready),
  .point_last  (point.last_of_run)
);
